### src/tga_pkg.sv
// shared constants and types of the run-length tga pixel decoder
// no dependencies; compile first

package tga_pkg;

	// width of the pixel and byte counters, 8 to 32
	localparam int COUNT_BITS = 24;

	// configuration register width and register indexes
	localparam int CFG_WIDTH = 24;

	typedef enum logic [0:0] {
		CFG_PIXEL_TOTAL    = 1'b0,
		CFG_PAYLOAD_LENGTH = 1'b1
	} cfg_reg_t;

	// packet header fields
	localparam int          RUN_FLAG_BIT = 7;
	localparam logic [7:0]  LEN_MASK     = 8'h7F;

	// a packet boundary with this many bytes left or fewer ends decoding
	localparam logic [COUNT_BITS-1:0] MIN_BYTES_LEFT = COUNT_BITS'(4);

	// position of the next byte within a pixel
	typedef enum logic [1:0] {
		BYTE_BLUE  = 2'd0,
		BYTE_GREEN = 2'd1,
		BYTE_RED   = 2'd2
	} pixel_byte_t;

	typedef struct packed {
		logic [7:0] blue_byte;
		logic [7:0] green_byte;
		logic [7:0] red_byte;
		logic [7:0] repeat_count;
		logic       image_done;
	} pixel_t;

endpackage

### src/tga_in_if.sv
// input channel of the tga decoder: one compressed payload byte per transaction
// no dependencies

interface tga_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_start;

	modport source (output valid, data_byte, frame_start, input ready);
	modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

### src/tga_out_if.sv
// output channel of the tga decoder: one decoded pixel per transaction
// no dependencies

interface tga_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue_byte;
	logic [7:0] green_byte;
	logic [7:0] red_byte;
	logic [7:0] repeat_count;
	logic       image_done;

	modport source (output valid, blue_byte, green_byte, red_byte, repeat_count, image_done,
		input ready);
	modport sink   (input valid, blue_byte, green_byte, red_byte, repeat_count, image_done,
		output ready);
endinterface

### src/tga_rle_pixel_decoder.sv
// top level of the run-length tga pixel decoder
// depends on tga_pkg, tga_in_if and tga_out_if

// Decodes the payload of a 24-bit run-length TGA image, one byte per cycle while pix_in.ready is high.
// Every byte after the 18-byte file header goes in on pix_in; the first byte
// of an image carries frame_start, which restarts decoding and loads the
// pixel and byte counters from pixel_total and payload_length (write those
// first, while the block is idle). Each pixel comes out on pix_out as blue,
// green and red with a repeat count, already clipped to the pixels that
// remain; image_done marks the pixel that completes the image. Header
// bytes and the first two bytes of a pixel give no transaction. Decoding
// stops at the pixel total, or at a packet boundary with 4 or fewer payload
// bytes left; bytes after that, and bytes before the first frame start,
// are swallowed. The decode state is updated in the cycle a byte is accepted
// and the pixel lands in the output or skid register, so a new byte can be
// accepted in every cycle while pix_in.ready is high. A two-entry output (register
// plus skid register) lets input keep flowing while one pixel waits for
// the sink; pix_in.ready drops only when both entries are full.

module tga_rle_pixel_decoder
	import tga_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  cfg_reg_t             cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data,
	tga_in_if.sink               pix_in,
	tga_out_if.source            pix_out
);

	// configuration registers
	logic [CFG_WIDTH-1:0] pixel_total_q;
	logic [CFG_WIDTH-1:0] payload_length_q;

	// decode state
	logic                  in_packet_q;
	logic                  is_run_q;
	logic [7:0]            pixels_in_packet_q;
	pixel_byte_t           byte_pos_q;
	logic [7:0]            blue_q;
	logic [7:0]            green_q;
	logic [COUNT_BITS-1:0] pixels_left_q;
	logic [COUNT_BITS-1:0] bytes_left_q;
	logic                  finished_q;

	// output register and skid register
	logic   out_valid_q;
	pixel_t out_q;
	logic   skid_valid_q;
	pixel_t skid_q;

	logic accept;

	// state as seen by this byte (frame start reloads it first)
	logic                  eff_in_packet;
	logic                  eff_is_run;
	logic [7:0]            eff_pip;
	pixel_byte_t           eff_pos;
	logic [COUNT_BITS-1:0] eff_pixels_left;
	logic [COUNT_BITS-1:0] eff_bytes_left;
	logic                  eff_finished;

	// next state
	logic                  nxt_in_packet;
	logic                  nxt_is_run;
	logic [7:0]            nxt_pip;
	pixel_byte_t           nxt_pos;
	logic [7:0]            nxt_blue;
	logic [7:0]            nxt_green;
	logic [COUNT_BITS-1:0] nxt_pixels_left;
	logic [COUNT_BITS-1:0] nxt_bytes_left;
	logic                  nxt_finished;

	logic       has_result;
	pixel_t     result;
	logic [7:0] hdr_len;
	logic [7:0] rep;

	assign pix_in.ready = !skid_valid_q;
	assign accept       = pix_in.valid && pix_in.ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_total_q    <= '0;
			payload_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PIXEL_TOTAL:    pixel_total_q    <= cfg_data;
				CFG_PAYLOAD_LENGTH: payload_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-byte decode
	always_comb begin
		if (pix_in.frame_start) begin
			eff_in_packet   = 1'b0;
			eff_is_run      = 1'b0;
			eff_pip         = '0;
			eff_pos         = BYTE_BLUE;
			eff_pixels_left = COUNT_BITS'(pixel_total_q);
			eff_bytes_left  = COUNT_BITS'(payload_length_q);
			eff_finished    = 1'b0;
		end else begin
			eff_in_packet   = in_packet_q;
			eff_is_run      = is_run_q;
			eff_pip         = pixels_in_packet_q;
			eff_pos         = byte_pos_q;
			eff_pixels_left = pixels_left_q;
			eff_bytes_left  = bytes_left_q;
			eff_finished    = finished_q;
		end

		nxt_in_packet   = eff_in_packet;
		nxt_is_run      = eff_is_run;
		nxt_pip         = eff_pip;
		nxt_pos         = eff_pos;
		nxt_blue        = blue_q;
		nxt_green       = green_q;
		nxt_pixels_left = eff_pixels_left;
		nxt_bytes_left  = eff_bytes_left;
		nxt_finished    = eff_finished;
		has_result      = 1'b0;
		hdr_len         = (pix_in.data_byte & LEN_MASK) + 8'd1;
		rep             = 8'd1;

		result.blue_byte    = blue_q;
		result.green_byte   = green_q;
		result.red_byte     = pix_in.data_byte;
		result.repeat_count = rep;
		result.image_done   = 1'b0;

		if (eff_finished) begin
			// swallowed byte
		end else if (!eff_in_packet) begin
			// packet header
			if (eff_pixels_left == '0 || eff_bytes_left <= MIN_BYTES_LEFT) begin
				nxt_finished = 1'b1;
			end else begin
				nxt_bytes_left = eff_bytes_left - COUNT_BITS'(1);
				nxt_is_run     = pix_in.data_byte[RUN_FLAG_BIT];
				nxt_pip        = hdr_len;
				// raw packets are clipped to the pixels left
				if (!pix_in.data_byte[RUN_FLAG_BIT]
					&& COUNT_BITS'(hdr_len) > eff_pixels_left) begin
					nxt_pip = 8'(eff_pixels_left);
				end
				nxt_pos       = BYTE_BLUE;
				nxt_in_packet = 1'b1;
			end
		end else begin
			// pixel byte; the byte count saturates at zero
			if (eff_bytes_left != '0) begin
				nxt_bytes_left = eff_bytes_left - COUNT_BITS'(1);
			end
			unique case (eff_pos)
				BYTE_BLUE: begin
					nxt_blue = pix_in.data_byte;
					nxt_pos  = BYTE_GREEN;
				end
				BYTE_GREEN: begin
					nxt_green = pix_in.data_byte;
					nxt_pos   = BYTE_RED;
				end
				BYTE_RED: begin
					nxt_pos = BYTE_BLUE;
					if (eff_is_run) begin
						rep     = eff_pip;
						nxt_pip = '0;
					end else begin
						rep     = 8'd1;
						nxt_pip = eff_pip - 8'd1;
					end
					// clip to the pixels left
					if (COUNT_BITS'(rep) > eff_pixels_left) begin
						rep = 8'(eff_pixels_left);
					end
					nxt_pixels_left = eff_pixels_left - COUNT_BITS'(rep);
					if (nxt_pip == '0) begin
						nxt_in_packet = 1'b0;
					end
					has_result          = 1'b1;
					result.repeat_count = rep;
					result.image_done   = (nxt_pixels_left == '0);
					if (nxt_pixels_left == '0) begin
						nxt_finished  = 1'b1;
						nxt_in_packet = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// decode state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q        <= 1'b0;
			is_run_q           <= 1'b0;
			pixels_in_packet_q <= '0;
			byte_pos_q         <= BYTE_BLUE;
			pixels_left_q      <= '0;
			bytes_left_q       <= '0;
			finished_q         <= 1'b1;
		end else if (accept) begin
			in_packet_q        <= nxt_in_packet;
			is_run_q           <= nxt_is_run;
			pixels_in_packet_q <= nxt_pip;
			byte_pos_q         <= nxt_pos;
			pixels_left_q      <= nxt_pixels_left;
			bytes_left_q       <= nxt_bytes_left;
			finished_q         <= nxt_finished;
		end
	end

	// held pixel bytes, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			blue_q  <= nxt_blue;
			green_q <= nxt_green;
		end
	end

	// output register and skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// no transaction on the input side; drain skid when output moves
				if (pix_out.ready) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept && has_result) begin
				if (out_valid_q && !pix_out.ready) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output and skid payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pix_out.ready) begin
				out_q <= skid_q;
			end
		end else if (accept && has_result) begin
			if (out_valid_q && !pix_out.ready) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign pix_out.valid        = out_valid_q;
	assign pix_out.blue_byte    = out_q.blue_byte;
	assign pix_out.green_byte   = out_q.green_byte;
	assign pix_out.red_byte     = out_q.red_byte;
	assign pix_out.repeat_count = out_q.repeat_count;
	assign pix_out.image_done   = out_q.image_done;

	// skid entry only ever sits behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register full while output register empty");

	// an emitted pixel always has a nonzero repeat count
	a_rep_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.repeat_count != 8'd0))
		else $error("pixel with zero repeat count");

	// an open packet always owes at least one pixel
	a_packet_owes: assert property (@(posedge clk) disable iff (!arst_n)
		in_packet_q |-> (pixels_in_packet_q != 8'd0 && pixels_left_q != '0))
		else $error("open packet with nothing left to emit");

	// completing the image stops decoding
	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && has_result && result.image_done) |=> (finished_q && !in_packet_q))
		else $error("decoder still running after image completed");

	// byte position stays within a pixel
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_pos_q == BYTE_BLUE) || (byte_pos_q == BYTE_GREEN) || (byte_pos_q == BYTE_RED))
		else $error("byte position out of range");

endmodule
